### hw/rtl/ethernet_ip_header_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// Ethernet IP header classifier assertion macros
// Shared assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IP_HEADER_CLASSIFIER_TOP_DEFINES_SVH
`define ETHERNET_IP_HEADER_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define EHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet IP header classifier package
// Constants, codes and the result type shared by the classifier files.
// ----------------------------------------------------------------------------
package ehc_pkg;

   localparam int unsigned DEF_MAX_EXT_HEADERS = 8;
   localparam int unsigned DEF_MAX_FRAME_BYTES = 65535;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

   localparam logic [3:0] IP_VER4 = 4'd4;
   localparam logic [3:0] IP_VER6 = 4'd6;

   // IP protocol / next-header numbers
   localparam logic [7:0] PROTO_HOPOPT  = 8'd0;
   localparam logic [7:0] PROTO_ICMP    = 8'd1;
   localparam logic [7:0] PROTO_TCP     = 8'd6;
   localparam logic [7:0] PROTO_UDP     = 8'd17;
   localparam logic [7:0] PROTO_ROUTING = 8'd43;
   localparam logic [7:0] PROTO_FRAG    = 8'd44;
   localparam logic [7:0] PROTO_ICMP6   = 8'd58;
   localparam logic [7:0] PROTO_DSTOPT  = 8'd60;

   // reported transport kind
   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_TCP   = 3'd1;
   localparam logic [2:0] KIND_UDP   = 3'd2;
   localparam logic [2:0] KIND_ICMP  = 3'd3;
   localparam logic [2:0] KIND_ICMP6 = 3'd4;

   typedef struct packed {
      logic [2:0]  ip_version;
      logic [2:0]  proto_kind;
      logic [63:0] source_high;
      logic [63:0] source_low;
      logic [63:0] dest_high;
      logic [63:0] dest_low;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] frame_bytes;
      logic        cut_short;
   } rsp_type;

   typedef struct packed {
      logic frame_open;
   } stat_type;

endpackage

### hw/rtl/ehc_if.sv
// ----------------------------------------------------------------------------
// Ethernet IP header classifier channels
// Valid/ready channels for frame bytes and classification results.
// ----------------------------------------------------------------------------
interface ehc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface ehc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  ip_version;
   logic [2:0]  proto_kind;
   logic [63:0] source_high;
   logic [63:0] source_low;
   logic [63:0] dest_high;
   logic [63:0] dest_low;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [15:0] frame_bytes;
   logic        cut_short;

   modport source (output valid, output ip_version, output proto_kind,
                   output source_high, output source_low, output dest_high,
                   output dest_low, output source_port, output dest_port,
                   output frame_bytes, output cut_short, input ready);
   modport sink   (input valid, input ip_version, input proto_kind,
                   input source_high, input source_low, input dest_high,
                   input dest_low, input source_port, input dest_port,
                   input frame_bytes, input cut_short, output ready);
endinterface

### hw/rtl/ehc_parser.sv
// ----------------------------------------------------------------------------
// Ethernet IP header classifier parser
// Per-frame header state, updated once per byte step; builds the result.
// ----------------------------------------------------------------------------
module ehc_parser #(
   parameter int unsigned MAX_EXT_HEADERS = ehc_pkg::DEF_MAX_EXT_HEADERS,
   parameter int unsigned MAX_FRAME_BYTES = ehc_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        data_byte,
   input  logic              frame_end,
   output ehc_pkg::rsp_type  rsp,
   output logic              rsp_ok,
   output ehc_pkg::stat_type stat
);

   localparam int unsigned CHAIN_W = $clog2(MAX_EXT_HEADERS + 1);

   localparam logic [15:0] POS_TYPE_HI = 16'd12;
   localparam logic [15:0] POS_TYPE_LO = 16'd13;
   localparam logic [15:0] POS_VER     = 16'd14;
   localparam logic [15:0] POS_V6_NH   = 16'd20;
   localparam logic [15:0] POS_V4_PROT = 16'd23;
   localparam logic [15:0] POS_V4_SRC  = 16'd26;
   localparam logic [15:0] POS_V4_DST  = 16'd30;
   localparam logic [15:0] POS_V4_END  = 16'd33;
   localparam logic [15:0] POS_V4_L4   = 16'd34;
   localparam logic [15:0] POS_V6_SRC  = 16'd22;
   localparam logic [15:0] POS_V6_DST  = 16'd38;
   localparam logic [15:0] POS_V6_END  = 16'd53;
   localparam logic [15:0] POS_V6_L4   = 16'd54;

   typedef struct packed {
      logic [15:0]              pos;
      logic [7:0]               type_hi;
      logic [3:0]               ver;
      logic [15:0]              bound;
      logic [7:0]               nxt;
      logic [CHAIN_W-1:0]       chain;
      logic [1:0][7:0][7:0]     src;
      logic [1:0][7:0][7:0]     dst;
      logic [1:0][1:0][7:0]     ports;
      logic                     rej;
      logic [2:0]               kind;
      logic                     resolved;
      logic                     addr_done;
      logic                     len_pend;
      logic                     frag;
      logic [2:0]               port_got;
   } frame_type;

   frame_type st_ff, st_in, upd;

   function automatic logic is_ext(input logic [7:0] t);
      return (t == ehc_pkg::PROTO_HOPOPT) || (t == ehc_pkg::PROTO_ROUTING) ||
             (t == ehc_pkg::PROTO_DSTOPT) || (t == ehc_pkg::PROTO_FRAG);
   endfunction

   // {resolve, kind} for an IPv6 next-header value
   function automatic logic [3:0] v6_next(input logic [7:0] t,
                                           input logic [CHAIN_W-1:0] cnt);
      logic [2:0] k;
      k = ehc_pkg::KIND_OTHER;
      if (t == ehc_pkg::PROTO_TCP)        k = ehc_pkg::KIND_TCP;
      else if (t == ehc_pkg::PROTO_UDP)   k = ehc_pkg::KIND_UDP;
      else if (t == ehc_pkg::PROTO_ICMP6) k = ehc_pkg::KIND_ICMP6;
      if (is_ext(t)) begin
         return {(cnt >= CHAIN_W'(MAX_EXT_HEADERS)), ehc_pkg::KIND_OTHER};
      end
      return {1'b1, k};
   endfunction

   logic [15:0] p;
   logic [16:0] port_at;
   logic [16:0] len_at;
   logic [16:0] nb;
   logic [3:0]  ihl;
   logic [3:0]  nx;
   logic [3:0]  ak;
   logic [1:0]  v4k;
   logic        can_port;
   logic        need_ports;

   always_comb begin
      upd      = st_ff;
      p        = st_ff.pos;
      port_at  = {1'b0, st_ff.bound} + {14'd0, st_ff.port_got};
      len_at   = {1'b0, st_ff.bound} + 17'd1;
      nb       = {1'b0, st_ff.bound} + 17'd8 +
                 (st_ff.frag ? 17'd0 : {6'd0, data_byte, 3'd0});
      ihl      = (data_byte[3:0] < 4'd5) ? 4'd5 : data_byte[3:0];
      nx       = '0;
      ak       = 4'(p - POS_V6_SRC);
      v4k      = 2'(p - POS_V4_SRC);
      can_port = st_ff.resolved && !st_ff.len_pend && (st_ff.port_got < 3'd4) &&
                 ((st_ff.kind == ehc_pkg::KIND_TCP) || (st_ff.kind == ehc_pkg::KIND_UDP)) &&
                 ({1'b0, p} == port_at);
      if (p < 16'(MAX_FRAME_BYTES)) begin
         upd.pos = p + 16'd1;
         if (!st_ff.rej) begin
            if (p == POS_TYPE_HI) begin
               upd.type_hi = data_byte;
            end else if (p == POS_TYPE_LO) begin
               if (({st_ff.type_hi, data_byte} != ehc_pkg::ETYPE_IPV4) &&
                   ({st_ff.type_hi, data_byte} != ehc_pkg::ETYPE_IPV6)) begin
                  upd.rej = 1'b1;
               end
            end else if (p == POS_VER) begin
               upd.ver = data_byte[7:4];
               if (data_byte[7:4] == ehc_pkg::IP_VER4) begin
                  upd.bound = 16'd14 + {10'd0, ihl, 2'd0};
               end else if (data_byte[7:4] == ehc_pkg::IP_VER6) begin
                  upd.bound = POS_V6_L4;
               end else begin
                  upd.rej = 1'b1;
               end
            end else if (p > POS_VER) begin
               if (st_ff.ver == ehc_pkg::IP_VER4) begin
                  if (p == POS_V4_PROT) begin
                     upd.nxt      = data_byte;
                     upd.resolved = 1'b1;
                     if (data_byte == ehc_pkg::PROTO_TCP)       upd.kind = ehc_pkg::KIND_TCP;
                     else if (data_byte == ehc_pkg::PROTO_UDP)  upd.kind = ehc_pkg::KIND_UDP;
                     else if (data_byte == ehc_pkg::PROTO_ICMP) upd.kind = ehc_pkg::KIND_ICMP;
                     else                                       upd.kind = ehc_pkg::KIND_OTHER;
                  end else if ((p >= POS_V4_SRC) && (p < POS_V4_DST)) begin
                     upd.src[1][{1'b0, ~v4k}] = data_byte;
                  end else if ((p >= POS_V4_DST) && (p <= POS_V4_END)) begin
                     upd.dst[1][{1'b0, ~v4k}] = data_byte;
                     if (p == POS_V4_END) upd.addr_done = 1'b1;
                  end
                  if ((p >= POS_V4_L4) && can_port) begin
                     upd.ports[st_ff.port_got[1]][~st_ff.port_got[0]] = data_byte;
                     upd.port_got = st_ff.port_got + 3'd1;
                  end
               end else begin
                  if (p == POS_V6_NH) begin
                     nx      = v6_next(data_byte, st_ff.chain);
                     upd.nxt = data_byte;
                     if (nx[3]) begin
                        upd.resolved = 1'b1;
                        upd.kind     = nx[2:0];
                     end
                  end else if ((p >= POS_V6_SRC) && (p < POS_V6_DST)) begin
                     upd.src[ak[3]][~ak[2:0]] = data_byte;
                  end else if ((p >= POS_V6_DST) && (p <= POS_V6_END)) begin
                     upd.dst[ak[3]][~ak[2:0]] = data_byte;
                     if (p == POS_V6_END) upd.addr_done = 1'b1;
                  end else if (p >= POS_V6_L4) begin
                     if (st_ff.len_pend) begin
                        if ({1'b0, p} == len_at) begin
                           upd.bound    = nb[16] ? 16'hFFFF : nb[15:0];
                           upd.len_pend = 1'b0;
                        end
                     end else if (!st_ff.resolved && is_ext(st_ff.nxt) &&
                                  (p == st_ff.bound)) begin
                        upd.frag     = (st_ff.nxt == ehc_pkg::PROTO_FRAG);
                        upd.len_pend = 1'b1;
                        upd.chain    = st_ff.chain + CHAIN_W'(1);
                        upd.nxt      = data_byte;
                        nx           = v6_next(data_byte, st_ff.chain + CHAIN_W'(1));
                        if (nx[3]) begin
                           upd.resolved = 1'b1;
                           upd.kind     = nx[2:0];
                        end
                     end else if (can_port) begin
                        upd.ports[st_ff.port_got[1]][~st_ff.port_got[0]] = data_byte;
                        upd.port_got = st_ff.port_got + 3'd1;
                     end
                  end
               end
            end
         end
      end
   end

   // build the result from the updated frame state
   always_comb begin
      need_ports      = (upd.kind == ehc_pkg::KIND_TCP) || (upd.kind == ehc_pkg::KIND_UDP);
      rsp_ok          = !upd.rej && ((upd.ver == ehc_pkg::IP_VER4) ||
                                     (upd.ver == ehc_pkg::IP_VER6));
      rsp.ip_version  = upd.ver[2:0];
      rsp.proto_kind  = upd.kind;
      rsp.source_high = upd.src[0];
      rsp.source_low  = upd.src[1];
      rsp.dest_high   = upd.dst[0];
      rsp.dest_low    = upd.dst[1];
      rsp.source_port = upd.ports[0];
      rsp.dest_port   = upd.ports[1];
      rsp.frame_bytes = upd.pos;
      rsp.cut_short   = !(upd.addr_done && upd.resolved &&
                          (!need_ports || (upd.port_got == 3'd4)));
      st_in           = frame_end ? '0 : upd;
      stat.frame_open = (st_ff.pos != 16'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

endmodule

### hw/rtl/ethernet_ip_header_classifier_top.sv
// A byte waits in the byte register; a last byte's step loads any result.
// Throughput: one byte per cycle; the byte register advances every cycle unless a
//   held result blocks a frame's last byte, and the result register loads on last bytes.
// Reset: synchronous, active high; clears frame state and both valid flags.
// A frame ending before byte 14, or with a wrong ethertype or IP version, yields
//   no result.
// ----------------------------------------------------------------------------
// Ethernet IP header classifier top level
// Byte-stream Ethernet IPv4/IPv6 parser reporting the five-tuple per frame.
// ----------------------------------------------------------------------------
`include "ethernet_ip_header_classifier_top_defines.svh"

module ethernet_ip_header_classifier_top #(
   parameter int unsigned MAX_EXT_HEADERS = ehc_pkg::DEF_MAX_EXT_HEADERS,
   parameter int unsigned MAX_FRAME_BYTES = ehc_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic     clock,
   input  logic     reset,
   ehc_req_if.sink  req_chan,
   ehc_rsp_if.source rsp_chan
);

   // byte register: holds one transferred byte until the parser steps
   logic       s1_v_ff, s1_v_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // result register
   logic             rsp_v_ff, rsp_v_in;
   ehc_pkg::rsp_type rsp_ff;

   ehc_pkg::rsp_type  prs_rsp;
   ehc_pkg::stat_type prs_stat;
   logic              prs_ok;

   logic out_free;
   logic adv;
   logic req_fire;
   logic rsp_load;

   // the result register frees when empty or when its transfer completes
   assign out_free = !rsp_v_ff || rsp_chan.ready;
   // only a frame's last byte needs room in the result register
   assign adv      = s1_v_ff && (!s1_last_ff || out_free);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_load = adv && s1_last_ff && prs_ok;

   assign req_chan.ready = !s1_v_ff || adv;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_fire)  s1_v_in = 1'b1;
      else if (adv)  s1_v_in = 1'b0;
      rsp_v_in = rsp_v_ff;
      if (rsp_load)            rsp_v_in = 1'b1;
      else if (rsp_chan.ready) rsp_v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // capture payloads; no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.frame_end;
      end
      if (rsp_load) begin
         rsp_ff <= prs_rsp;
      end
   end

   ehc_parser #(
      .MAX_EXT_HEADERS (MAX_EXT_HEADERS),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (adv),
      .data_byte (s1_byte_ff),
      .frame_end (s1_last_ff),
      .rsp       (prs_rsp),
      .rsp_ok    (prs_ok),
      .stat      (prs_stat)
   );

   // drive the result channel
   assign rsp_chan.valid       = rsp_v_ff;
   assign rsp_chan.ip_version  = rsp_ff.ip_version;
   assign rsp_chan.proto_kind  = rsp_ff.proto_kind;
   assign rsp_chan.source_high = rsp_ff.source_high;
   assign rsp_chan.source_low  = rsp_ff.source_low;
   assign rsp_chan.dest_high   = rsp_ff.dest_high;
   assign rsp_chan.dest_low    = rsp_ff.dest_low;
   assign rsp_chan.source_port = rsp_ff.source_port;
   assign rsp_chan.dest_port   = rsp_ff.dest_port;
   assign rsp_chan.frame_bytes = rsp_ff.frame_bytes;
   assign rsp_chan.cut_short   = rsp_ff.cut_short;

   // a byte arriving into a full byte register must see it advance
   `EHC_ASSERT_NOW(a_no_overrun, clock, reset, req_fire && s1_v_ff, adv,
      "byte register overrun")
   // frame state returns to the start once the last byte steps through
   `EHC_ASSERT_NEXT(a_frame_clear, clock, reset, adv && s1_last_ff,
      !prs_stat.frame_open, "frame state not cleared after last byte")
   // a delivered result always carries IPv4 or IPv6
   `EHC_ASSERT_NOW(a_version, clock, reset, rsp_v_ff,
      (rsp_ff.ip_version == 3'(ehc_pkg::IP_VER4)) || (rsp_ff.ip_version == 3'(ehc_pkg::IP_VER6)),
      "result with bad IP version")

endmodule
